@@ hw/rtl/crc24ls_pkg.sv @@
// shared types and constants for the length-seeded crc-24 core
package crc24ls_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned POLY_W = 24;
  localparam int unsigned OUT_W  = 24;

  // openpgp generator polynomial, x^24 term dropped
  localparam logic [POLY_W-1:0] POLY_RESET = 24'h864cfb;

  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [POLY_W-1:0] poly_t;
  typedef logic [OUT_W-1:0]  crc_out_t;

  typedef struct packed {
    byte_t data_byte;
    logic  first;
    logic  last;
    len_t  msg_length;
  } in_item_t;

endpackage

@@ hw/rtl/crc24ls_if.sv @@
// valid/ready channel interfaces for byte input, crc result and polynomial writes
interface crc24ls_in_if;
  logic                valid;
  logic                ready;
  crc24ls_pkg::byte_t  data_byte;
  logic                first;
  logic                last;
  crc24ls_pkg::len_t   msg_length;

  modport source (output valid, data_byte, first, last, msg_length, input ready);
  modport sink   (input valid, data_byte, first, last, msg_length, output ready);
endinterface

interface crc24ls_out_if;
  logic                  valid;
  logic                  ready;
  crc24ls_pkg::crc_out_t crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

interface crc24ls_cfg_if;
  logic               valid;
  logic               ready;
  crc24ls_pkg::poly_t crc_poly;

  modport source (output valid, crc_poly, input ready);
  modport sink   (input valid, crc_poly, output ready);
endinterface

@@ hw/rtl/crc24ls_fold.sv @@
// seed select and eight-step msb-first byte fold of the crc accumulator
module crc24ls_fold #(
  parameter int unsigned CRC_WIDTH = 24
) (
  input  logic [CRC_WIDTH-1:0] acc,
  input  crc24ls_pkg::byte_t   data_byte,
  input  logic                 seed,
  input  crc24ls_pkg::len_t    msg_length,
  input  crc24ls_pkg::poly_t   crc_poly,
  output logic [CRC_WIDTH-1:0] crc_nxt
);
  import crc24ls_pkg::*;

  logic [CRC_WIDTH-1:0] start;
  logic [CRC_WIDTH-1:0] poly_w;
  logic [CRC_WIDTH-1:0] work;

  assign poly_w = CRC_WIDTH'(crc_poly);

  always_comb begin
    // seed is (length + first byte) modulo 2^width
    start = seed ? (CRC_WIDTH'(msg_length) + CRC_WIDTH'(data_byte)) : acc;
    work  = start ^ (CRC_WIDTH'(data_byte) << (CRC_WIDTH - DATA_W));
    for (int k = 0; k < DATA_W; k++) begin
      if (work[CRC_WIDTH-1]) begin
        work = (work << 1) ^ poly_w;
      end else begin
        work = work << 1;
      end
    end
    crc_nxt = work;
  end

endmodule

@@ hw/rtl/crc24_length_seeded_core.sv @@
// top level of the length-seeded msb-first crc-24 core
// Takes one message byte per cycle while the input is not stalled and returns
// the CRC on the byte marked last. A byte marked first seeds the accumulator
// with (msg_length + byte) modulo 2^CRC_WIDTH; that byte and every following
// one are folded in MSB-first with the polynomial held in the cfg register
// (reset: 0x864cfb). The fold from the input register into the accumulator
// register is combinational; a result enters the result register when its
// last byte is folded. The input stalls only when a last byte finds the result
// register still full. Polynomial writes take effect from the next byte folded.
module crc24_length_seeded_core #(
  parameter int unsigned CRC_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  crc24ls_in_if.sink           in_ch,
  crc24ls_out_if.source        out_ch,
  crc24ls_cfg_if.sink          cfg_ch
);
  import crc24ls_pkg::*;

  // input stage
  logic     s1_v_r, s1_v_nxt;
  in_item_t s1_item_r;

  // accumulator, polynomial and result register
  logic [CRC_WIDTH-1:0] accum_r, accum_nxt;
  poly_t                poly_r;
  logic                 out_v_r, out_v_nxt;
  crc_out_t             out_crc_r;

  logic in_xfer;
  logic advance;

  // staged byte is folded unless it is last and the result slot cannot take it
  assign advance = s1_v_r && (!s1_item_r.last || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || advance;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_v_r;
  assign out_ch.crc_value = out_crc_r;

  crc24ls_fold #(
    .CRC_WIDTH (CRC_WIDTH)
  ) u_fold (
    .acc        (accum_r),
    .data_byte  (s1_item_r.data_byte),
    .seed       (s1_item_r.first),
    .msg_length (s1_item_r.msg_length),
    .crc_poly   (poly_r),
    .crc_nxt    (accum_nxt)
  );

  always_comb begin
    if (in_xfer) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_comb begin
    if (advance && s1_item_r.last) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      accum_r <= '0;
      poly_r  <= POLY_RESET;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (advance) begin
        accum_r <= accum_nxt;
      end
      if (cfg_ch.valid) begin
        poly_r <= cfg_ch.crc_poly;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.data_byte  <= in_ch.data_byte;
      s1_item_r.first      <= in_ch.first;
      s1_item_r.last       <= in_ch.last;
      s1_item_r.msg_length <= in_ch.msg_length;
    end
    if (advance && s1_item_r.last) begin
      out_crc_r <= OUT_W'(accum_nxt);
    end
  end

  // a folded last byte always lands in the result register
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_item_r.last |=> out_v_r)
    else $error("folded last byte did not produce a result");

  // input only stalls behind a blocked last byte
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && s1_item_r.last && out_v_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

  // a transferred byte is held in the input stage
  a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_v_r)
    else $error("accepted byte missing from input stage");

  // accumulator only moves when a byte is folded
  a_accum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(accum_r))
    else $error("accumulator changed without a folded byte");

endmodule

@@ test/crc24ls_checker.sv @@
// checker for the length-seeded crc-24 core: predicts each crc from the byte transfers and compares
`timescale 1ns / 1ps
module crc24ls_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  crc24ls_pkg::byte_t    in_data_byte,
  input  logic                  in_first,
  input  logic                  in_last,
  input  crc24ls_pkg::len_t     in_msg_length,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  crc24ls_pkg::crc_out_t out_crc_value,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  crc24ls_pkg::poly_t    cfg_crc_poly,
  output int                    fail_count,
  output int                    crc_due_cnt
);
  import crc24ls_pkg::*;

  poly_t    poly_now;
  crc_out_t crc_run;
  crc_out_t crc_due_q[$];

  // msb-first fold of one byte, eight shift and conditional xor steps
  function automatic crc_out_t crc_after_byte(crc_out_t acc, byte_t b, poly_t p);
    crc_out_t a;
    a = acc ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      if (a[OUT_W-1]) a = (a << 1) ^ p;
      else a = a << 1;
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, crc_out_t want_crc, crc_out_t got_crc);
    $display("%0t ns: %s: expected %06h got %06h", $time, what, want_crc, got_crc);
    fail_count++;
  endtask

  always @(posedge clk) begin
    crc_out_t want;
    if (!rst_n) begin
      poly_now   = POLY_RESET;
      crc_run    = '0;
      fail_count = 0;
      crc_due_q.delete();
    end else begin
      // results first, so a crc due at this edge is never matched to itself
      if (out_valid && out_ready) begin
        if (crc_due_q.size() == 0) begin
          report_mismatch("result with no crc due", '0, out_crc_value);
        end else begin
          want = crc_due_q.pop_front();
          if (out_crc_value !== want) report_mismatch("crc_value", want, out_crc_value);
        end
      end
      if (in_valid && in_ready) begin
        if (in_first) crc_run = in_msg_length + len_t'(in_data_byte);
        crc_run = crc_after_byte(crc_run, in_data_byte, poly_now);
        if (in_last) crc_due_q.push_back(crc_run);
      end
      if (cfg_valid && cfg_ready) poly_now = cfg_crc_poly;
    end
    crc_due_cnt <= crc_due_q.size();
  end

endmodule

@@ test/tb_crc24_length_seeded_core.sv @@
// testbench top for crc24_length_seeded_core: byte stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module tb_crc24_length_seeded_core;
  import crc24ls_pkg::*;

  localparam int NUM_ITEMS       = 1650;
  localparam int HOLD_OFF_CYCLES = 300;     // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES    = 6;
  localparam int QUIET_LIMIT     = 20000;
  localparam int RUN_LIMIT_NS    = 4000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   crc_due_cnt;
  int   items_sent;
  bit   hold_off_req;
  int   send_run;
  int   sink_run;
  int   sink_stall;

  crc24ls_in_if  in_ch();
  crc24ls_out_if out_ch();
  crc24ls_cfg_if cfg_ch();

  crc24_length_seeded_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  crc24ls_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data_byte  (in_ch.data_byte),
    .in_first      (in_ch.first),
    .in_last       (in_ch.last),
    .in_msg_length (in_ch.msg_length),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_crc_value (out_ch.crc_value),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_crc_poly  (cfg_ch.crc_poly),
    .fail_count    (fail_count),
    .crc_due_cnt   (crc_due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle length: drawn from three ranges, the shortest most often and a long pause rarely
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 94) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // sender gap: half the transfers back to back, plus occasional runs with no idling
  function automatic int sender_gap();
    if (send_run > 0) begin
      send_run--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      send_run = $urandom_range(20, 60);
      return 0;
    end
    return ($urandom_range(0, 1) == 0) ? 0 : idle_len();
  endfunction

  // offer one byte after gap idle cycles and return at the edge of its transfer;
  // valid stays high so the next byte can follow without a bubble
  task automatic send_byte(byte_t b, logic is_first, logic is_last, len_t len, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first      <= is_first;
    in_ch.last       <= is_last;
    in_ch.msg_length <= len;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // well-formed message, length field only meaningful on the first byte
  task automatic send_message(int n, len_t len_field);
    for (int i = 0; i < n; i++)
      send_byte(byte_t'($urandom), i == 0, i == n - 1,
                (i == 0) ? len_field : len_t'($urandom), sender_gap());
  endtask

  // stop offering, wait until every due crc has been seen, then let the
  // pipeline drain bytes that carry no result
  task automatic wait_quiet();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (crc_due_cnt != 0 && n < QUIET_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // polynomial write, only while the block is idle
  task automatic write_poly(poly_t p);
    wait_quiet();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.crc_poly <= p;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, stretches of steady ready, and one long hold-off on request
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    sink_stall = 0;
    sink_run   = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req <= 1'b0;
        out_ch.ready <= 1'b1;
      end else if (sink_stall > 0) begin
        out_ch.ready <= 1'b0;
        sink_stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_run > 0) sink_run--;
        else if ($urandom_range(0, 4) == 0) sink_stall = idle_len();
        else if ($urandom_range(0, 59) == 0) sink_run = $urandom_range(30, 120);
      end
    end
  end

  initial begin : stimulus
    int    pick;
    int    msg_len;
    int    cut;
    int    stop_at;
    int    base_cnt;
    len_t  len_field;
    poly_t phase_poly;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.first      <= 1'b0;
    in_ch.last       <= 1'b0;
    in_ch.msg_length <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.crc_poly  <= POLY_RESET;
    items_sent = 0;
    send_run   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // stray bytes straight after reset fold into the zero accumulator
    send_byte(8'hff, 1'b0, 1'b0, 24'h000000, 0);
    send_byte(8'h00, 1'b0, 1'b1, 24'hffffff, 1);
    // one-byte messages at the seed extremes, length plus byte wraps
    send_byte(8'hff, 1'b1, 1'b1, 24'hffffff, 0);
    send_byte(8'h00, 1'b1, 1'b1, 24'h000000, 0);
    send_byte(8'h80, 1'b1, 1'b1, 24'h000001, 2);
    // three-byte message, length field ignored after the first byte
    send_byte(8'h01, 1'b1, 1'b0, 24'h000003, 0);
    send_byte(8'ha5, 1'b0, 1'b0, 24'h555555, 0);
    send_byte(8'h5a, 1'b0, 1'b1, 24'haaaaaa, 0);
    // no first after last: continues from the crc just given
    send_byte(8'h7e, 1'b0, 1'b1, 24'h000000, 3);
    // second first inside a message reseeds
    send_byte(8'h10, 1'b1, 1'b0, 24'h000005, 0);
    send_byte(8'h20, 1'b1, 1'b0, 24'h000007, 0);
    send_byte(8'h30, 1'b0, 1'b1, 24'h000000, 0);
    // polynomial change in the middle of a message
    send_byte(8'h33, 1'b1, 1'b0, 24'h000002, 0);
    write_poly(24'h000000);
    send_byte(8'h44, 1'b0, 1'b1, 24'h000000, 0);
    write_poly(24'hffffff);
    send_byte(8'hff, 1'b1, 1'b1, 24'hffffff, 0);
    send_byte(8'h01, 1'b1, 1'b0, 24'h000002, 0);
    send_byte(8'hc3, 1'b0, 1'b1, 24'h000000, 0);
    write_poly(24'h000001);
    send_byte(8'h9c, 1'b1, 1'b0, 24'h800000, 0);
    send_byte(8'hff, 1'b0, 1'b1, 24'h000000, 0);

    // random part, one polynomial per phase, extremes included
    base_cnt = items_sent;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       phase_poly = POLY_RESET;
        2:       phase_poly = 24'h000000;
        3:       phase_poly = 24'hffffff;
        4:       phase_poly = 24'h800000;
        default: phase_poly = poly_t'($urandom);
      endcase
      write_poly(phase_poly);
      stop_at = base_cnt + (ph + 1) * NUM_ITEMS / 6;

      if (ph == 1) begin
        // receiver holds off while one-byte messages keep coming: the
        // result register fills and the input has to stall
        hold_off_req <= 1'b1;
        for (int i = 0; i < 60; i++)
          send_byte(byte_t'($urandom), 1'b1, 1'b1, len_t'($urandom), 0);
      end

      while (items_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) msg_len = $urandom_range(1, 6);
          else if (pick < 92) msg_len = $urandom_range(7, 24);
          else msg_len = $urandom_range(25, 64);
          pick = $urandom_range(0, 99);
          if (pick < 70) len_field = len_t'(msg_len);
          else if (pick < 85) len_field = len_t'($urandom);
          else if (pick < 93) len_field = 24'hffffff - len_t'($urandom_range(0, 255));
          else len_field = len_t'($urandom_range(0, 2));
          send_message(msg_len, len_field);
        end else if (pick < 94) begin
          // stray byte outside any message
          send_byte(byte_t'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                    len_t'($urandom), sender_gap());
        end else begin
          // broken message: never ends, the next first reseeds
          cut = $urandom_range(1, 5);
          for (int i = 0; i < cut; i++)
            send_byte(byte_t'($urandom), i == 0, 1'b0, len_t'($urandom), sender_gap());
        end
      end
    end

    wait_quiet();
    if (fail_count == 0 && crc_due_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
